>>> design/drc_pkg.sv
// ----------------------------------------------------------------------------
// drc_pkg
// Types, constants and helper functions shared by the duplicate-request cache.
// ----------------------------------------------------------------------------
package drc_pkg;

  localparam int ENTRIES    = 64;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int PROC_COUNT = 18;
  localparam int MASK_W     = 18;
  localparam int ADDR_W     = 4;

  // register indices, taken from address bits [3:2]
  localparam logic [1:0] REG_DELAY  = 2'd0;
  localparam logic [1:0] REG_NONIDEM = 2'd1;
  localparam logic [1:0] REG_STATUS = 2'd2;

  localparam logic [7:0]        DELAY_RST  = 8'd2;
  localparam logic [MASK_W-1:0] NONIDEM_RST = 18'd65284;
  localparam logic [MASK_W-1:0] STATUS_RST = 18'd48128;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam logic [1:0] PH_UNUSED = 2'd0;
  localparam logic [1:0] PH_INPROG = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  localparam int KIND_STATUS_BIT = 0;
  localparam int KIND_BODY_BIT   = 1;

  localparam logic [2:0] ACT_DROP         = 3'd0;
  localparam logic [2:0] ACT_REPLY_STATUS = 3'd1;
  localparam logic [2:0] ACT_REPLY_BODY   = 3'd2;
  localparam logic [2:0] ACT_DOIT         = 3'd3;
  localparam logic [2:0] ACT_UPDATED      = 3'd4;
  localparam logic [2:0] ACT_NOMATCH      = 3'd5;

  typedef struct packed {
    logic        opcode;
    logic [31:0] request_id;
    logic [31:0] client_addr;
    logic [4:0]  procedure;
    logic [31:0] reply_status;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] cached_status;
    logic [5:0]  entry_index;
  } rsp_t;

  typedef struct packed {
    logic [31:0]      xid;
    logic [31:0]      client;
    logic [4:0]       proc_num;
    logic [1:0]       phase;
    logic [1:0]       kind;
    logic [31:0]      stamp;
    logic [31:0]      status;
    logic [IDX_W-1:0] rank;
  } entry_t;

  // flag of a procedure in a mask; out-of-range procedures count as clear
  function automatic logic proc_flag(input logic [MASK_W-1:0] mask, input logic [4:0] p);
    logic [31:0] wide;
    wide = {{(32-MASK_W){1'b0}}, mask} >> p;
    return (32'(p) < PROC_COUNT) && wide[0];
  endfunction

  // repeat inside the drop window, signed 32-bit difference
  function automatic logic within_delay(input logic [31:0] now, input logic [31:0] then_s,
                                        input logic [7:0] dly);
    logic [31:0] d;
    d = now - then_s;
    return d[31] || (d < {24'd0, dly});
  endfunction

endpackage

>>> design/duplicate_request_cache.sv
// ----------------------------------------------------------------------------
// duplicate_request_cache
// Duplicate-request cache with LRU replacement, scanned serially over one
// entry memory with one read port and one write port.
// ----------------------------------------------------------------------------
//  channel  | signals                         | handshake
//  ---------+---------------------------------+------------------------------
//  request  | start, busy, req                | taken when start & !busy
//  result   | done, result                    | one-cycle strobe, no stall
//  config   | psel penable pwrite paddr pwdata| APB, pready tied high
//           | prdata pready                   |
//
// A transaction runs a match scan over all entries, a pipeline wait state, a
// decision state and a read-modify-write sweep that ages the LRU ranks on
// lookups and updates the target entry, then the result state. An update that
// finds no match skips the sweep and goes from the decision to the result.
// Synchronous reset invalidates all entries at once through per-entry valid
// bits; no clearing pass is needed. The result cannot be stalled.
module duplicate_request_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  drc_pkg::req_t                 req,
  output logic                          done,
  output drc_pkg::rsp_t                 result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [drc_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import drc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_SCAN      = 6'b000010,
    S_SCAN_WAIT = 6'b000100,
    S_DECIDE    = 6'b001000,
    S_SWEEP     = 6'b010000,
    S_RESULT    = 6'b100000
  } state_t;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(ENTRIES - 1);

  state_t state;

  // configuration registers
  logic [7:0]        delay_seconds;
  logic [MASK_W-1:0] nonidempotent_mask;
  logic [MASK_W-1:0] status_only_mask;

  // captured transaction and scan results
  req_t             cur;
  logic             found;
  logic [IDX_W-1:0] match_idx;
  logic [IDX_W-1:0] match_rank;
  logic [IDX_W-1:0] victim_idx;
  logic [IDX_W-1:0] target;
  logic [IDX_W-1:0] old_rank;
  logic [IDX_W-1:0] addr;
  logic             sweep_last;

  // memory and read pipeline
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_raw;
  logic               rd_valid_bit;
  logic               rd_vld;
  logic               rd_scan;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             ent;
  logic               rd_en;

  // write side
  logic   we;
  entry_t wdata;
  logic [2:0]  act_next;
  logic [31:0] cstat_next;
  rsp_t   res;

  logic cfg_wr;
  logic hit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_RESULT);
  assign result = res;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_seconds      <= DELAY_RST;
      nonidempotent_mask <= NONIDEM_RST;
      status_only_mask   <= STATUS_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_DELAY:   delay_seconds      <= pwdata[7:0];
        REG_NONIDEM: nonidempotent_mask <= pwdata[MASK_W-1:0];
        REG_STATUS:  status_only_mask   <= pwdata[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_DELAY:   prdata = {24'd0, delay_seconds};
      REG_NONIDEM: prdata = {{(32-MASK_W){1'b0}}, nonidempotent_mask};
      REG_STATUS:  prdata = {{(32-MASK_W){1'b0}}, status_only_mask};
      default:     prdata = 32'd0;
    endcase
  end

  // entry memory: one read, one write per cycle
  assign rd_en = (state == S_SCAN) || (state == S_SWEEP);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw       <= mem[addr];
      rd_valid_bit <= valid[addr];
    end
    if (we) begin
      mem[rd_idx] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[rd_idx] <= 1'b1;
    end
  end

  // an entry never written reads as its reset value
  always_comb begin
    if (rd_valid_bit) begin
      ent = rd_raw;
    end else begin
      ent      = '0;
      ent.rank = rd_idx;
    end
  end

  assign hit = (ent.phase != PH_UNUSED) && (ent.xid == cur.request_id) &&
               (ent.client == cur.client_addr) && (ent.proc_num == cur.procedure);

  // sweep: age ranks on lookups and rewrite the target entry
  always_comb begin
    we         = rd_vld && !rd_scan;
    wdata      = ent;
    act_next   = ACT_UPDATED;
    cstat_next = 32'd0;
    if (cur.opcode == OP_LOOKUP && ent.rank > old_rank) begin
      wdata.rank = ent.rank - IDX_W'(1);
    end
    if (rd_idx == target) begin
      if (cur.opcode == OP_UPDATE) begin
        wdata.phase = PH_DONE;
        wdata.stamp = cur.now_seconds;
        if (proc_flag(nonidempotent_mask, cur.procedure)) begin
          if (proc_flag(status_only_mask, cur.procedure)) begin
            wdata.status                = cur.reply_status;
            wdata.kind[KIND_STATUS_BIT] = 1'b1;
          end else begin
            wdata.kind[KIND_BODY_BIT] = 1'b1;
          end
        end
      end else if (found) begin
        wdata.rank = LAST;
        if (ent.phase == PH_INPROG ||
            within_delay(cur.now_seconds, ent.stamp, delay_seconds)) begin
          act_next = ACT_DROP;
        end else if (ent.kind[KIND_STATUS_BIT]) begin
          act_next    = ACT_REPLY_STATUS;
          cstat_next  = ent.status;
          wdata.stamp = cur.now_seconds;
        end else if (ent.kind[KIND_BODY_BIT]) begin
          act_next    = ACT_REPLY_BODY;
          wdata.stamp = cur.now_seconds;
        end else begin
          act_next    = ACT_DOIT;
          wdata.phase = PH_INPROG;
        end
      end else begin
        wdata.rank     = LAST;
        wdata.kind     = 2'd0;
        wdata.phase    = PH_INPROG;
        wdata.xid      = cur.request_id;
        wdata.client   = cur.client_addr;
        wdata.proc_num = cur.procedure;
        act_next       = ACT_DOIT;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= rd_en;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (addr == LAST) begin
            state <= S_SCAN_WAIT;
          end
        end
        S_SCAN_WAIT: state <= S_DECIDE;
        S_DECIDE: begin
          if (cur.opcode == OP_UPDATE && !found) begin
            state <= S_RESULT;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (sweep_last) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath registers of the sequencer
  always_ff @(posedge clk) begin
    rd_scan <= (state == S_SCAN);
    rd_idx  <= addr;
    case (state)
      S_IDLE: begin
        cur        <= req;
        addr       <= '0;
        found      <= 1'b0;
        sweep_last <= 1'b0;
      end
      S_SCAN: begin
        addr <= addr + IDX_W'(1);
      end
      S_DECIDE: begin
        addr       <= '0;
        target     <= found ? match_idx : victim_idx;
        old_rank   <= found ? match_rank : '0;
        res.action        <= ACT_NOMATCH;
        res.cached_status <= 32'd0;
        res.entry_index   <= '0;
      end
      S_SWEEP: begin
        if (addr != LAST) begin
          addr <= addr + IDX_W'(1);
        end
        sweep_last <= (addr == LAST);
      end
      default: ;
    endcase
    // collect the first match and the oldest entry
    if (rd_vld && rd_scan) begin
      if (hit && !found) begin
        found      <= 1'b1;
        match_idx  <= rd_idx;
        match_rank <= ent.rank;
      end
      if (ent.rank == '0) begin
        victim_idx <= rd_idx;
      end
    end
    // latch the answer when the target comes by
    if (we && rd_idx == target) begin
      res.action        <= act_next;
      res.cached_status <= cstat_next;
      res.entry_index   <= 6'(rd_idx);
    end
  end

  // checks
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_nomatch_idx: assert property (@(posedge clk) disable iff (rst)
    done && result.action == ACT_NOMATCH |-> result.entry_index == '0)
    else $error("no-match result carries an entry index");

  a_status_only: assert property (@(posedge clk) disable iff (rst)
    done && result.cached_status != 32'd0 |-> result.action == ACT_REPLY_STATUS)
    else $error("status word on a result that is not a status reply");

endmodule
